[rtl/core/adpcm_pkg.sv]
package adpcm_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned POS_W   = 16;

    localparam logic [INDEX_W-1:0] MAX_INDEX = 5'd30;
    localparam logic [POS_W-1:0]   MIN_CLIP  = 16'd3;

    // decoder state carried between the control and the code step
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [INDEX_W-1:0] index;
    } adpcm_state_t;

    // step size table, one entry per step index
    function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                5'd0:    s = 7'd7;
                5'd1:    s = 7'd8;
                5'd2:    s = 7'd8;
                5'd3:    s = 7'd9;
                5'd4:    s = 7'd10;
                5'd5:    s = 7'd11;
                5'd6:    s = 7'd12;
                5'd7:    s = 7'd14;
                5'd8:    s = 7'd15;
                5'd9:    s = 7'd17;
                5'd10:   s = 7'd18;
                5'd11:   s = 7'd20;
                5'd12:   s = 7'd22;
                5'd13:   s = 7'd24;
                5'd14:   s = 7'd27;
                5'd15:   s = 7'd29;
                5'd16:   s = 7'd32;
                5'd17:   s = 7'd35;
                5'd18:   s = 7'd39;
                5'd19:   s = 7'd43;
                5'd20:   s = 7'd47;
                5'd21:   s = 7'd52;
                5'd22:   s = 7'd57;
                5'd23:   s = 7'd63;
                5'd24:   s = 7'd69;
                5'd25:   s = 7'd76;
                5'd26:   s = 7'd83;
                5'd27:   s = 7'd92;
                5'd28:   s = 7'd101;
                5'd29:   s = 7'd111;
                default: s = 7'd122;
            endcase
            return s;
        end
    endfunction

endpackage

[rtl/core/adpcm_code_step.sv]
module adpcm_code_step (
    input  adpcm_pkg::adpcm_state_t cur,
    input  logic [3:0]              code,
    output adpcm_pkg::adpcm_state_t nxt
);
    import adpcm_pkg::*;

    logic [INDEX_W-1:0] idx;
    logic [STEP_W-1:0]  step;
    logic [LEVEL_W-1:0] mag;
    logic [LEVEL_W:0]   sum;
    logic [INDEX_W:0]   idx_up;

    // index saturated to the table range
    assign idx  = (cur.index > MAX_INDEX) ? MAX_INDEX : cur.index;
    assign step = step_lookup(idx);

    // shift-add magnitude from code bits 2..0
    always_comb
    begin
        mag = {1'b0, step} >> 3;
        if (code[2])
        begin
            mag = mag + {1'b0, step};
        end
        if (code[1])
        begin
            mag = mag + ({1'b0, step} >> 1);
        end
        if (code[0])
        begin
            mag = mag + ({1'b0, step} >> 2);
        end
    end

    // signed update with floor at zero and ceiling at full scale
    assign sum = {1'b0, cur.level} + {1'b0, mag};

    always_comb
    begin
        if (code[3])
        begin
            nxt.level = (mag >= cur.level) ? '0 : (cur.level - mag);
        end
        else
        begin
            nxt.level = sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
        end
    end

    // index move: down by one for small codes, up by 2/4/6/8 otherwise
    assign idx_up = {1'b0, idx} + {3'b000, code[1:0], 1'b0} + 6'd2;

    always_comb
    begin
        if (code[2])
        begin
            nxt.index = (idx_up > {1'b0, MAX_INDEX}) ? MAX_INDEX : idx_up[INDEX_W-1:0];
        end
        else
        begin
            nxt.index = (idx == '0) ? '0 : (idx - 5'd1);
        end
    end

endmodule

[rtl/core/adpcm_nibble_decoder.sv]
// a byte is captured in the hold register and each of its results is loaded into the output register
// a code byte gives two results, one per nibble through the shared code step, and waits
// while the output stalls; the next byte is accepted as the held byte's last step fires
// reset (rst_n, async active low): level 0, step index 0, next byte is a clip header,
// clip length 65535, no item held and no result pending
module adpcm_nibble_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  level,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] clip_bytes
);
    import adpcm_pkg::*;

    logic [POS_W-1:0]   clip_reg;
    adpcm_state_t       state_reg, state_next;
    adpcm_state_t       step_out;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [7:0]         hold_byte_reg;
    logic               hi_phase_reg, hi_phase_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               is_hdr0, is_hdr1;
    logic               step_fire, byte_done, in_take, out_load;
    logic [POS_W-1:0]   last_pos;
    logic [3:0]         code;

    assign is_hdr0   = (pos_reg == '0);
    assign is_hdr1   = (pos_reg == 16'd1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_fire = hold_valid_reg && (is_hdr0 || out_free);
    assign byte_done = step_fire && (is_hdr0 || is_hdr1 || hi_phase_reg);
    assign out_load  = step_fire && !is_hdr0;

    assign in_stall  = hold_valid_reg && !byte_done;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = !hold_valid_reg && !out_valid_reg;

    // position of the last byte of a clip, short lengths act as three
    assign last_pos = (clip_reg < MIN_CLIP) ? (MIN_CLIP - 16'd1) : (clip_reg - 16'd1);

    assign code = hi_phase_reg ? hold_byte_reg[7:4] : hold_byte_reg[3:0];

    adpcm_code_step u_step (
        .cur  (state_reg),
        .code (code),
        .nxt  (step_out)
    );

    // per-cycle control and decoder state update
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        hi_phase_next   = hi_phase_reg;
        level_next      = level_reg;
        last_next       = last_reg;
        hold_valid_next = hold_valid_reg;
        if (step_fire)
        begin
            if (is_hdr0)
            begin
                state_next.level = hold_byte_reg;
                pos_next         = 16'd1;
            end
            else if (is_hdr1)
            begin
                state_next.index = (hold_byte_reg > {3'b000, MAX_INDEX}) ?
                                   MAX_INDEX : hold_byte_reg[INDEX_W-1:0];
                pos_next         = 16'd2;
                level_next       = state_reg.level;
                last_next        = 1'b1;
            end
            else
            begin
                state_next = step_out;
                level_next = step_out.level;
                last_next  = hi_phase_reg;
                if (hi_phase_reg)
                begin
                    hi_phase_next = 1'b0;
                    pos_next      = (pos_reg >= last_pos) ? '0 : (pos_reg + 16'd1);
                end
                else
                begin
                    hi_phase_next = 1'b1;
                end
            end
        end
        if (in_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (byte_done)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // output register handshake
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg       <= 16'hFFFF;
            state_reg      <= '0;
            pos_reg        <= '0;
            hold_valid_reg <= 1'b0;
            hi_phase_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                clip_reg <= clip_bytes;
            end
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            hold_valid_reg <= hold_valid_next;
            hi_phase_reg   <= hi_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_byte_reg <= data_byte;
        end
        level_reg <= level_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign level       = level_reg;
    assign last_of_run = last_reg;

endmodule

[rtl/core/adpcm_checker.sv]
module adpcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  level,
    input logic        last_of_run,
    input logic        cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(last_of_run))
        else $error("stalled result changed");

    // no register write while a result is pending
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cfg_ready)
        else $error("config ready while result pending");

    // high nibble follows the low one without a gap
    a_hi_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && !out_stall |=> out_valid)
        else $error("second code result missing");

    // byte in progress blocks a new item while its low result is stalled
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && out_stall |-> in_stall)
        else $error("new item taken mid byte");

endmodule

bind adpcm_nibble_decoder adpcm_checker u_adpcm_checker (.*);
